[rtl/lru_pkg.sv]
// Shared constants and types for the LRU page replacement unit.
package lru_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int STAMP_W   = 32;
    localparam int LIMIT_W   = 5;
    localparam int MEM_W     = PAGE_BITS + STAMP_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } state_t;

endpackage

[rtl/lru_page_replacement_unit.sv]
// LRU page replacement unit: frame store in one synchronous RAM, one reference per beat.
// Per reference: the scan reads every frame from the RAM in turn and compares each, then the update writes.
// A new reference is taken only in idle, once the scan, compare and update of the last one are done.
// The result register frees the input side; update waits only while a result is still unread.
// Reset clears valid bits and counters and sets the frame limit to 16; the RAM holds no reset.
module lru_page_replacement_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,  // frame_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // page_number
    input  logic        s_tlast,      // last_reference
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // evicted_page[15:0], fault_total[47:16]
    output logic [1:0]  m_tuser,      // hit[0], evicted_valid[1]
    output logic        m_tlast       // final_count
);

    lru_pkg::state_t state_reg, state_next;

    logic [lru_pkg::MEM_W-1:0]     mem [lru_pkg::FRAMES];
    logic [lru_pkg::MEM_W-1:0]     rdata_reg;
    logic [lru_pkg::FRAMES-1:0]    valid_reg;
    logic [lru_pkg::IDX_W-1:0]     addr_reg;
    logic [lru_pkg::IDX_W-1:0]     cmp_idx_reg;
    logic                          cmp_en_reg;
    logic [lru_pkg::PAGE_BITS-1:0] page_reg;
    logic                          last_reg;
    logic [lru_pkg::LIMIT_W-1:0]   limit_reg;
    logic [lru_pkg::STAMP_W-1:0]   ref_cnt_reg;
    logic [31:0]                   fault_cnt_reg;
    logic                          hit_reg;
    logic [lru_pkg::IDX_W-1:0]     hit_idx_reg;
    logic [lru_pkg::STAMP_W-1:0]   best_age_reg;
    logic [lru_pkg::IDX_W-1:0]     best_idx_reg;
    logic [lru_pkg::PAGE_BITS-1:0] best_page_reg;
    logic                          m_tvalid_reg;
    logic [47:0]                   m_tdata_reg;
    logic [1:0]                    m_tuser_reg;
    logic                          m_tlast_reg;

    logic [lru_pkg::CNT_W-1:0]     lim;
    logic                          rd_en;
    logic                          upd_go;
    logic                          out_free;
    logic                          free_found;
    logic [lru_pkg::IDX_W-1:0]     free_idx;
    logic [lru_pkg::IDX_W-1:0]     slot;
    logic [lru_pkg::PAGE_BITS-1:0] q_page;
    logic [lru_pkg::STAMP_W-1:0]   q_stamp;
    logic [lru_pkg::STAMP_W-1:0]   q_age;
    logic                          q_in_lim;
    logic [31:0]                   fault_next;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (limit_reg == '0) begin
            lim = lru_pkg::CNT_W'(1);
        end else if (32'(limit_reg) > 32'(lru_pkg::FRAMES)) begin
            lim = lru_pkg::CNT_W'(lru_pkg::FRAMES);
        end else begin
            lim = lru_pkg::CNT_W'(limit_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lru_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lru_pkg::ST_SCAN;
            end
            lru_pkg::ST_SCAN: begin
                if (addr_reg == lru_pkg::IDX_W'(lru_pkg::FRAMES - 1)) begin
                    state_next = lru_pkg::ST_LAST;
                end
            end
            lru_pkg::ST_LAST: state_next = lru_pkg::ST_UPDATE;
            lru_pkg::ST_UPDATE: begin
                if (out_free) state_next = lru_pkg::ST_IDLE;
            end
            default: state_next = lru_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        upd_go   = 1'b0;
        unique case (state_reg)
            lru_pkg::ST_IDLE:   s_tready = 1'b1;
            lru_pkg::ST_SCAN:   rd_en    = 1'b1;
            lru_pkg::ST_LAST:   ;
            lru_pkg::ST_UPDATE: upd_go   = out_free;
            default:            ;
        endcase
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = lru_pkg::FRAMES - 1; i >= 0; i--) begin
            if (lru_pkg::CNT_W'(i) < lim && !valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = lru_pkg::IDX_W'(i);
            end
        end
    end

    assign q_page   = rdata_reg[lru_pkg::MEM_W-1:lru_pkg::STAMP_W];
    assign q_stamp  = rdata_reg[lru_pkg::STAMP_W-1:0];
    assign q_age    = ref_cnt_reg - q_stamp;
    assign q_in_lim = lru_pkg::CNT_W'(cmp_idx_reg) < lim;

    always_comb begin
        priority if (hit_reg) begin
            slot = hit_idx_reg;
        end else if (free_found) begin
            slot = free_idx;
        end else begin
            slot = best_idx_reg;
        end
    end

    assign fault_next = (fault_cnt_reg != '1) ? fault_cnt_reg + 32'd1 : fault_cnt_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr_reg];
        end
        if (upd_go) begin
            mem[slot] <= {page_reg, ref_cnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lru_pkg::ST_IDLE;
            limit_reg     <= lru_pkg::LIMIT_RESET;
            valid_reg     <= '0;
            ref_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            addr_reg      <= '0;
            cmp_en_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cmp_en_reg <= rd_en;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                addr_reg <= '0;
                hit_reg  <= 1'b0;
            end
            if (rd_en) begin
                addr_reg <= addr_reg + lru_pkg::IDX_W'(1);
            end
            if (cmp_en_reg && !hit_reg && valid_reg[cmp_idx_reg] && q_page == page_reg) begin
                hit_reg <= 1'b1;
            end
            if (upd_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (upd_go) begin
                if (last_reg) begin
                    valid_reg     <= '0;
                    ref_cnt_reg   <= '0;
                    fault_cnt_reg <= '0;
                end else begin
                    valid_reg[slot] <= 1'b1;
                    ref_cnt_reg     <= ref_cnt_reg + lru_pkg::STAMP_W'(1);
                    if (!hit_reg) fault_cnt_reg <= fault_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            page_reg <= lru_pkg::PAGE_BITS'(s_tdata);
            last_reg <= s_tlast;
        end
        if (rd_en) begin
            cmp_idx_reg <= addr_reg;
        end
        if (cmp_en_reg) begin
            if (!hit_reg && valid_reg[cmp_idx_reg] && q_page == page_reg) begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (q_in_lim && (cmp_idx_reg == '0 || q_age > best_age_reg)) begin
                best_age_reg  <= q_age;
                best_idx_reg  <= cmp_idx_reg;
                best_page_reg <= q_page;
            end
        end
        if (upd_go) begin
            m_tuser_reg[0] <= hit_reg;
            m_tuser_reg[1] <= !hit_reg && !free_found;
            m_tdata_reg[15:0] <= (!hit_reg && !free_found) ? 16'(best_page_reg) : 16'd0;
            m_tdata_reg[47:16] <= hit_reg ? fault_cnt_reg : fault_next;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == lru_pkg::ST_SCAN && addr_reg == '0)
        else $error("scan did not start at frame zero");

    a_hit_frame_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lru_pkg::ST_UPDATE && hit_reg |-> valid_reg[hit_idx_reg])
        else $error("hit on an empty frame");

    a_fault_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go && !last_reg |=> fault_cnt_reg >= $past(fault_cnt_reg))
        else $error("fault count went down within a sequence");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("eviction reported on a hit");
`endif

endmodule
